// File: hdl/positional_insert_erase_list_unit_macros.svh
// Assertion macros for the positional insert/erase list unit.
// Used by the checker; expects signals named clock and reset in scope.
`ifndef POSITIONAL_INSERT_ERASE_LIST_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_ERASE_LIST_UNIT_MACROS_SVH

// Same-cycle implication.
`define PIEL_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PIEL_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/piel_pkg.sv
// Shared types and constants for the positional insert/erase list unit.
// No dependencies.
package piel_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LEN_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int MODE_W = 3;
   localparam int POS_W  = 9;
   localparam int CNT_W  = 9;
   localparam int STAT_W = 2;
   localparam int SUM_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ   = 3'd0,
      MODE_WRITE  = 3'd1,
      MODE_INSERT = 3'd2,
      MODE_ERASE  = 3'd3,
      MODE_PUSH   = 3'd4,
      MODE_POP    = 3'd5,
      MODE_RESIZE = 3'd6,
      MODE_CLEAR  = 3'd7
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT,
      ST_MOVE,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
      status_type               status;
   } result_type;

endpackage

// File: hdl/piel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module piel_ram #(
   parameter int WIDTH   = 32,
   parameter int ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/piel_seq.sv
// Request sequencer: decodes an item, checks bounds, and steps a shared
// cursor/offset adder to move or fill list entries one per cycle.
// Depends on piel_pkg.
module piel_seq
   import piel_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [POS_W-1:0]         req_position,
   input  logic [CNT_W-1:0]         req_count,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     out_free,
   output logic                     busy,
   output logic                     done,
   output result_type               result,
   output logic                     rd_en,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic [DATA_W-1:0]        rd_data,
   output logic                     wr_en,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic [DATA_W-1:0]        wr_data
);

   state_type                state_ff, state_in;
   mode_type                 mode_ff, mode_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DATA_W-1:0]        val_ff, val_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         cur_ff, cur_in;
   logic [LEN_W-1:0]         rem_ff, rem_in;
   logic [LEN_W-1:0]         delta_ff, delta_in;
   logic                     dn_ff, dn_in;
   logic                     pend_ff, pend_in;
   logic [ADDR_W-1:0]        pend_addr_ff, pend_addr_in;
   logic signed [DATA_W-1:0] rdv_ff, rdv_in;
   status_type               st_ff, st_in;

   logic [SUM_W-1:0] len_x, pos_x, cnt_x, depth_x;
   logic             pos_ge_len, pos_gt_len, ins_full, cnt_gt_depth;
   logic             len_full, len_zero, cnt_zero, grow, rem_zero, rem_one;
   logic [LEN_W-1:0] addr_sum, cur_step;

   assign len_x        = SUM_W'(len_ff);
   assign pos_x        = SUM_W'(pos_ff);
   assign cnt_x        = SUM_W'(cnt_ff);
   assign depth_x      = SUM_W'(DEPTH);
   assign pos_ge_len   = pos_x >= len_x;
   assign pos_gt_len   = pos_x > len_x;
   assign ins_full     = (len_x + cnt_x) > depth_x;
   assign cnt_gt_depth = cnt_x > depth_x;
   assign len_full     = len_x >= depth_x;
   assign len_zero     = len_ff == '0;
   assign cnt_zero     = cnt_ff == '0;
   assign grow         = cnt_x > len_x;
   assign rem_zero     = rem_ff == '0;
   assign rem_one      = rem_ff == LEN_W'(1);

   // shared address unit
   assign addr_sum = cur_ff + delta_ff;
   assign cur_step = dn_ff ? (cur_ff - LEN_W'(1)) : (cur_ff + LEN_W'(1));

   assign busy   = state_ff != ST_IDLE;
   assign result = '{read_value: rdv_ff, length: len_ff, status: st_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (mode_ff)
               MODE_READ:   state_in = pos_ge_len ? ST_DONE : ST_RDWAIT;
               MODE_WRITE:  state_in = pos_ge_len ? ST_DONE : ST_FILL;
               MODE_INSERT: state_in = (pos_gt_len || ins_full || cnt_zero) ? ST_DONE
                                                                             : ST_MOVE;
               MODE_ERASE:  state_in = pos_ge_len ? ST_DONE : ST_MOVE;
               MODE_PUSH:   state_in = len_full ? ST_DONE : ST_FILL;
               MODE_RESIZE: state_in = (!cnt_gt_depth && grow) ? ST_FILL : ST_DONE;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_RDWAIT: state_in = ST_DONE;
         ST_MOVE: begin
            if (rem_zero) state_in = (mode_ff == MODE_INSERT) ? ST_FILL : ST_DONE;
         end
         ST_FILL: begin
            if (rem_one) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      delta_in     = delta_ff;
      dn_in        = dn_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rdv_in       = rdv_ff;
      st_in        = st_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cur_ff[ADDR_W-1:0];
      wr_data      = val_ff;
      done         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = mode_type'(req_mode);
               pos_in  = req_position;
               cnt_in  = req_count;
               val_in  = req_value;
            end
         end
         ST_EXEC: begin
            rdv_in  = '0;
            st_in   = STAT_OK;
            pend_in = 1'b0;
            dn_in   = 1'b0;
            unique case (mode_ff)
               MODE_READ: begin
                  if (pos_ge_len) begin
                     st_in = STAT_RANGE;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = pos_ff[ADDR_W-1:0];
                  end
               end
               MODE_WRITE: begin
                  if (pos_ge_len) begin
                     st_in = STAT_RANGE;
                  end else begin
                     cur_in = LEN_W'(pos_ff);
                     rem_in = LEN_W'(1);
                  end
               end
               MODE_INSERT: begin
                  if (pos_gt_len) begin
                     st_in = STAT_RANGE;
                  end else if (ins_full) begin
                     st_in = STAT_FULL;
                  end else if (!cnt_zero) begin
                     len_in   = LEN_W'(len_x + cnt_x);
                     cur_in   = len_ff - LEN_W'(1);
                     rem_in   = LEN_W'(len_x - pos_x);
                     delta_in = LEN_W'(cnt_ff);
                     dn_in    = 1'b1;
                  end
               end
               MODE_ERASE: begin
                  if (pos_ge_len) begin
                     st_in = STAT_RANGE;
                  end else begin
                     len_in   = len_ff - LEN_W'(1);
                     cur_in   = LEN_W'(pos_x + SUM_W'(1));
                     rem_in   = LEN_W'(len_x - pos_x - SUM_W'(1));
                     delta_in = '1;
                  end
               end
               MODE_PUSH: begin
                  if (len_full) begin
                     st_in = STAT_FULL;
                  end else begin
                     cur_in = len_ff;
                     rem_in = LEN_W'(1);
                     len_in = len_ff + LEN_W'(1);
                  end
               end
               MODE_POP: begin
                  if (len_zero) begin
                     st_in = STAT_EMPTY;
                  end else begin
                     len_in = len_ff - LEN_W'(1);
                  end
               end
               MODE_RESIZE: begin
                  if (cnt_gt_depth) begin
                     st_in = STAT_FULL;
                  end else begin
                     len_in = LEN_W'(cnt_ff);
                     if (grow) begin
                        cur_in = len_ff;
                        rem_in = LEN_W'(cnt_x - len_x);
                     end
                  end
               end
               MODE_CLEAR: len_in = '0;
               default: st_in = STAT_OK;
            endcase
         end
         ST_RDWAIT: rdv_in = rd_data;
         ST_MOVE: begin
            // read one entry per cycle, write the previous one behind it
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = rd_data;
            end
            if (!rem_zero) begin
               rd_en        = 1'b1;
               rd_addr      = cur_ff[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = addr_sum[ADDR_W-1:0];
               cur_in       = cur_step;
               rem_in       = rem_ff - LEN_W'(1);
            end else begin
               pend_in = 1'b0;
               if (mode_ff == MODE_INSERT) begin
                  cur_in = LEN_W'(pos_ff);
                  rem_in = LEN_W'(cnt_ff);
                  dn_in  = 1'b0;
               end
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff[ADDR_W-1:0];
            wr_data = val_ff;
            cur_in  = cur_step;
            rem_in  = rem_ff - LEN_W'(1);
         end
         ST_DONE: done = out_free;
         default: done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      cnt_ff       <= cnt_in;
      val_ff       <= val_in;
      cur_ff       <= cur_in;
      rem_ff       <= rem_in;
      delta_ff     <= delta_in;
      dn_ff        <= dn_in;
      pend_addr_ff <= pend_addr_in;
      rdv_ff       <= rdv_in;
      st_ff        <= st_in;
   end

endmodule

// File: hdl/positional_insert_erase_list_unit.sv
// Positional insert/erase list unit: top level with output register.
// Depends on piel_pkg, piel_ram and piel_seq.
//
// Ordered list of up to 256 signed 32-bit words in a RAM with one write port
// and one registered read port (one write and one read per cycle) plus a length register.
// One item is worked at a time; req_stall stays high from acceptance until
// the result is handed to the output register, which may still hold the
// previous result while the next item is accepted. Read, write, push, pop,
// clear, shrink and rejected requests touch at most one RAM entry. Insert
// moves the (length - position) entries from position on up by count, then
// fills count entries at position; erase moves the entries after position
// down by one; a growing resize fills (new length - old length) entries.
// Moved or filled entries go through the RAM write port one per cycle. An
// item can also wait in DONE while rsp_stall holds the output register.
// The RAM needs no initialization after reset.
module positional_insert_erase_list_unit
   import piel_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [POS_W-1:0]         req_position,
   input  logic [CNT_W-1:0]         req_count,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]         rsp_length,
   output logic [STAT_W-1:0]        rsp_status
);

   logic                     busy, done, out_free;
   result_type               result;
   logic                     rd_en, wr_en;
   logic [ADDR_W-1:0]        rd_addr, wr_addr;
   logic [DATA_W-1:0]        rd_data, wr_data;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_read_value_ff;
   logic [LEN_W-1:0]         rsp_length_ff;
   logic [STAT_W-1:0]        rsp_status_ff;

   piel_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_count    (req_count),
      .req_value    (req_value),
      .out_free     (out_free),
      .busy         (busy),
      .done         (done),
      .result       (result),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   piel_ram #(
      .WIDTH   (DATA_W),
      .ENTRIES (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall    = busy;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_read_value_ff <= result.read_value;
         rsp_length_ff     <= result.length;
         rsp_status_ff     <= result.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// File: hdl/piel_checker.sv
// Port-level checker for the positional insert/erase list unit, with bind.
// Depends on piel_pkg and positional_insert_erase_list_unit_macros.svh.
`include "positional_insert_erase_list_unit_macros.svh"

module piel_checker
   import piel_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_read_value,
   input logic [STAT_W-1:0]        rsp_status
);

   `PIEL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled item dropped")
   `PIEL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy after accept")
   `PIEL_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "result while idle")
   `PIEL_ASSERT_NOW(a_reject_zero, rsp_valid && (rsp_status != STAT_OK), rsp_read_value == '0, "rejected item has data")

endmodule

bind positional_insert_erase_list_unit piel_checker u_piel_checker (.*);
